// ----- hdl/sfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // histogram size and counter width
    localparam int SYMBOLS     = 100;
    localparam int COUNT_WIDTH = 16;

    // share in hundredths of a percent
    localparam int SHARE_SCALE = 10000;
    localparam int SCALE_W     = 14;

    localparam int IDX_W  = $clog2(SYMBOLS);
    localparam int CUR_W  = $clog2(SYMBOLS + 1);
    localparam int DIVD_W = COUNT_WIDTH + SCALE_W;
    localparam int DCNT_W = $clog2(DIVD_W);

    localparam int OP_W    = 3;
    localparam int SYM_W   = 7;
    localparam int OCC_W   = 16;
    localparam int SHARE_W = 14;

    typedef logic [OP_W-1:0]        op_t;
    typedef logic [SYM_W-1:0]       sym_t;
    typedef logic [OCC_W-1:0]       occ_t;
    typedef logic [SHARE_W-1:0]     share_t;
    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CUR_W-1:0]       cur_t;
    typedef logic [DIVD_W-1:0]      prod_t;
    typedef logic [DCNT_W-1:0]      dcnt_t;

    localparam op_t OP_CLEAR      = 3'd0;
    localparam op_t OP_ADD        = 3'd1;
    localparam op_t OP_NEXT_ORDER = 3'd2;
    localparam op_t OP_NEXT_FREQ  = 3'd3;
    localparam op_t OP_REWIND     = 3'd4;

    localparam cnt_t  CNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam cur_t  SYM_END   = cur_t'(SYMBOLS);
    localparam prod_t SCALE_P   = prod_t'(SHARE_SCALE);

    // controller to datapath
    typedef struct packed {
        logic clear_all;
        logic rewind;
        logic add_read;
        logic add_write;
        logic scan_start;
        logic mode_freq;
        logic scan_step;
        logic mul_load;
        logic result_load;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sym_ok;
        logic scan_done;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/sfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sfr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit a cycle
module sfr_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sfr_pkg::prod_t dividend,
    input  wire sfr_pkg::cnt_t  divisor,
    output logic               busy,
    output sfr_pkg::prod_t     quotient
);

    sfr_pkg::prod_t q_reg, q_next;
    sfr_pkg::cnt_t  rem_reg, rem_next;
    sfr_pkg::dcnt_t cnt_reg, cnt_next;
    logic           busy_reg, busy_next;

    logic [sfr_pkg::COUNT_WIDTH:0] trial;
    logic [sfr_pkg::COUNT_WIDTH:0] dsr_ext;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, q_reg[sfr_pkg::DIVD_W-1]};
        dsr_ext   = {1'b0, divisor};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= dsr_ext)
            begin
                rem_next = sfr_pkg::cnt_t'(trial - dsr_ext);
                q_next   = {q_reg[sfr_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = sfr_pkg::cnt_t'(trial);
                q_next   = {q_reg[sfr_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sfr_pkg::dcnt_t'(sfr_pkg::DIVD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- hdl/sfr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire sfr_pkg::op_t        op,
    input  wire sfr_pkg::dp_status_t status,
    output logic                     in_stall,
    output sfr_pkg::ctl_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        sfr_pkg::OP_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        sfr_pkg::OP_ADD:
                        begin
                            if (status.sym_ok)
                            begin
                                cmd.add_read = 1'b1;
                                state_next   = S_ADD;
                            end
                        end
                        sfr_pkg::OP_NEXT_ORDER:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        sfr_pkg::OP_NEXT_FREQ:
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.mode_freq  = 1'b1;
                            state_next     = S_SCAN;
                        end
                        sfr_pkg::OP_REWIND:
                        begin
                            cmd.rewind = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/sfr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sfr_pkg::sym_t     symbol,
    input  wire sfr_pkg::ctl_cmd_t cmd,
    input  wire logic              out_stall,
    output sfr_pkg::dp_status_t    status,
    output logic                   out_valid,
    output sfr_pkg::sym_t          out_symbol,
    output sfr_pkg::occ_t          occurrences,
    output sfr_pkg::share_t        share_hundredths,
    output logic                   exhausted
);

    // per-entry flags: count nonzero, taken in frequency order
    logic [sfr_pkg::SYMBOLS-1:0] cnt_vld_reg, cnt_vld_next;
    logic [sfr_pkg::SYMBOLS-1:0] taken_reg, taken_next;

    sfr_pkg::cnt_t total_reg, total_next;
    sfr_pkg::cur_t cursor_reg, cursor_next;

    sfr_pkg::idx_t add_idx_reg, add_idx_next;

    // scan pipeline
    logic          mode_reg, mode_next;
    sfr_pkg::cur_t issue_reg, issue_next;
    logic          pend_vld_reg, pend_vld_next;
    sfr_pkg::idx_t pend_idx_reg, pend_idx_next;
    logic          found_reg, found_next;
    sfr_pkg::idx_t best_idx_reg, best_idx_next;
    sfr_pkg::cnt_t best_cnt_reg, best_cnt_next;

    logic              out_valid_reg, out_valid_next;
    sfr_pkg::sym_t     out_symbol_reg, out_symbol_next;
    sfr_pkg::occ_t     occ_reg, occ_next;
    sfr_pkg::share_t   share_reg, share_next;
    logic              exh_reg, exh_next;

    logic          ram_we;
    sfr_pkg::cnt_t ram_wdata;
    logic          ram_re;
    sfr_pkg::idx_t ram_raddr;
    sfr_pkg::cnt_t ram_rdata;

    logic           issue_live;
    logic           cand;
    logic           take;
    sfr_pkg::cnt_t  old_cnt;
    sfr_pkg::prod_t quotient;
    logic           div_busy;

    assign issue_live = (issue_reg != sfr_pkg::SYM_END);
    assign old_cnt    = cnt_vld_reg[add_idx_reg] ? ram_rdata : '0;

    assign ram_re    = cmd.add_read || (cmd.scan_step && issue_live);
    assign ram_raddr = cmd.add_read ? sfr_pkg::idx_t'(symbol) : sfr_pkg::idx_t'(issue_reg);
    assign ram_we    = cmd.add_write;
    assign ram_wdata = (old_cnt == sfr_pkg::CNT_MAX) ? old_cnt : old_cnt + 1'b1;

    // candidate entry in the compare stage
    assign cand = pend_vld_reg && cnt_vld_reg[pend_idx_reg]
                  && (!mode_reg || !taken_reg[pend_idx_reg]);
    assign take = cand && (mode_reg ? (!found_reg || ram_rdata > best_cnt_reg) : !found_reg);

    sfr_ram #(
        .WIDTH (sfr_pkg::COUNT_WIDTH),
        .DEPTH (sfr_pkg::SYMBOLS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (add_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mul_load),
        .dividend (sfr_pkg::prod_t'(best_cnt_reg) * sfr_pkg::SCALE_P),
        .divisor  (total_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        cnt_vld_next    = cnt_vld_reg;
        taken_next      = taken_reg;
        total_next      = total_reg;
        cursor_next     = cursor_reg;
        add_idx_next    = add_idx_reg;
        mode_next       = mode_reg;
        issue_next      = issue_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_symbol_next = out_symbol_reg;
        occ_next        = occ_reg;
        share_next      = share_reg;
        exh_next        = exh_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.clear_all)
        begin
            cnt_vld_next = '0;
            taken_next   = '0;
            total_next   = '0;
            cursor_next  = '0;
        end

        if (cmd.rewind)
        begin
            taken_next  = '0;
            cursor_next = '0;
        end

        if (cmd.add_read)
        begin
            add_idx_next = sfr_pkg::idx_t'(symbol);
        end

        if (cmd.add_write)
        begin
            cnt_vld_next[add_idx_reg] = 1'b1;
            if (total_reg != sfr_pkg::CNT_MAX)
            begin
                total_next = total_reg + 1'b1;
            end
        end

        if (cmd.scan_start)
        begin
            mode_next     = cmd.mode_freq;
            issue_next    = cmd.mode_freq ? '0 : cursor_reg;
            pend_vld_next = 1'b0;
            found_next    = 1'b0;
            best_idx_next = '0;
            best_cnt_next = '0;
        end

        if (cmd.scan_step)
        begin
            pend_vld_next = issue_live;
            pend_idx_next = sfr_pkg::idx_t'(issue_reg);
            if (issue_live)
            begin
                issue_next = issue_reg + 1'b1;
            end
            if (take)
            begin
                found_next    = 1'b1;
                best_idx_next = pend_idx_reg;
                best_cnt_next = ram_rdata;
            end
        end

        if (cmd.result_load)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = sfr_pkg::sym_t'(best_idx_reg);
            occ_next        = sfr_pkg::occ_t'(best_cnt_reg);
            exh_next        = !found_reg;
            if (total_reg == '0)
            begin
                share_next = '0;
            end
            else if (quotient > sfr_pkg::SCALE_P)
            begin
                share_next = sfr_pkg::share_t'(sfr_pkg::SHARE_SCALE);
            end
            else
            begin
                share_next = sfr_pkg::share_t'(quotient);
            end
            if (found_reg)
            begin
                if (mode_reg)
                begin
                    taken_next[best_idx_reg] = 1'b1;
                end
                else
                begin
                    cursor_next = sfr_pkg::cur_t'(best_idx_reg) + 1'b1;
                end
            end
            else if (!mode_reg)
            begin
                cursor_next = sfr_pkg::SYM_END;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg   <= '0;
            taken_reg     <= '0;
            total_reg     <= '0;
            cursor_reg    <= '0;
            pend_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_vld_reg   <= cnt_vld_next;
            taken_reg     <= taken_next;
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            pend_vld_reg  <= pend_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_idx_reg    <= add_idx_next;
        mode_reg       <= mode_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_cnt_reg   <= best_cnt_next;
        out_symbol_reg <= out_symbol_next;
        occ_reg        <= occ_next;
        share_reg      <= share_next;
        exh_reg        <= exh_next;
    end

    always_comb
    begin
        status.sym_ok    = (32'(symbol) < 32'(sfr_pkg::SYMBOLS));
        status.scan_done = !issue_live && !pend_vld_reg;
        status.div_busy  = div_busy;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign out_symbol       = out_symbol_reg;
    assign occurrences      = occ_reg;
    assign share_hundredths = share_reg;
    assign exhausted        = exh_reg;

endmodule

`default_nettype wire

// ----- hdl/symbol_frequency_ranker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// input     in         in_valid / in_stall   op, symbol
// output    out        out_valid / out_stall out_symbol, occurrences, share_hundredths,
//                                            exhausted
//
// clear and rewind are done as the beat is taken, an add reads the count ram, then writes back
// a report scans the count ram, one entry a cycle, then runs a bit-serial divide for
//   the share
// reset clears the per-symbol nonzero flags at once, so there is no clearing pass
// a finished report waits in the sequencer until a stalled beat drains from the output
// register; the input stays stalled meanwhile, so no add, clear or rewind beat is taken
module symbol_frequency_ranker_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    // input beats
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire sfr_pkg::op_t    op,
    input  wire sfr_pkg::sym_t   symbol,
    // result beats
    output logic                 out_valid,
    input  wire logic            out_stall,
    output sfr_pkg::sym_t        out_symbol,
    output sfr_pkg::occ_t        occurrences,
    output sfr_pkg::share_t      share_hundredths,
    output logic                 exhausted
);

    // commands from the sequencer, status back from the datapath
    sfr_pkg::ctl_cmd_t   cmd;
    sfr_pkg::dp_status_t status;

    // sequencer: decodes the beat and steps the scan, divide and output hand-off
    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // datapath: count ram, flags, scan pipeline, divider and output register
    sfr_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .symbol           (symbol),
        .cmd              (cmd),
        .out_stall        (out_stall),
        .status           (status),
        .out_valid        (out_valid),
        .out_symbol       (out_symbol),
        .occurrences      (occurrences),
        .share_hundredths (share_hundredths),
        .exhausted        (exhausted)
    );

endmodule

`default_nettype wire

// ----- hdl/sfr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_stall,
    input  wire sfr_pkg::op_t    op,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  wire sfr_pkg::sym_t   out_symbol,
    input  wire sfr_pkg::occ_t   occurrences,
    input  wire sfr_pkg::share_t share_hundredths,
    input  wire logic            exhausted
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_symbol)
            && $stable(occurrences) && $stable(share_hundredths) && $stable(exhausted))
        else $error("stalled result beat changed");

    // nothing-left beat carries zeros
    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> out_symbol == '0 && occurrences == '0
            && share_hundredths == '0)
        else $error("exhausted beat with nonzero payload");

    // a reported symbol was counted and its share is in range
    a_found_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !exhausted |-> occurrences != '0
            && share_hundredths <= sfr_pkg::share_t'(sfr_pkg::SHARE_SCALE))
        else $error("reported symbol with zero count or share above full");

    // a report request holds off the next beat while it scans
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == sfr_pkg::OP_NEXT_ORDER || op == sfr_pkg::OP_NEXT_FREQ)
            |=> in_stall)
        else $error("report request did not hold off the input");

endmodule

bind symbol_frequency_ranker_top sfr_checker u_sfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .occurrences      (occurrences),
    .share_hundredths (share_hundredths),
    .exhausted        (exhausted)
);

`default_nettype wire

// ----- bench/symbol_frequency_ranker_top_tb.sv -----
`timescale 1ns / 1ps

module symbol_frequency_ranker_top_tb;

    import sfr_pkg::*;

    // op codes the block has no use for
    localparam op_t OP_SPARE5 = 3'd5;
    localparam op_t OP_SPARE6 = 3'd6;
    localparam op_t OP_SPARE7 = 3'd7;

    // one report beat as the block should drive it
    typedef struct packed {
        sym_t   sym;
        occ_t   occ;
        share_t share;
        logic   none;
    } report_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    op_t    op;
    sym_t   symbol;
    logic   out_valid;
    logic   out_stall;
    sym_t   out_symbol;
    occ_t   occurrences;
    share_t share_hundredths;
    logic   exhausted;

    // own copy of the histogram and both report orders
    cnt_t        hist [SYMBOLS];
    bit          picked [SYMBOLS];
    cnt_t        grand_total;
    int unsigned seq_cursor;

    // reports owed by the block, oldest first
    report_t reports_due [$];

    int          mismatches    = 0;
    int unsigned beats_sent    = 0;
    // no idling on that side while set
    bit          tx_eager      = 1'b0;
    bit          rx_eager      = 1'b0;
    // one long result hold-off, picked up by the stall driver
    int          rx_hold_cycles = 0;

    symbol_frequency_ranker_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .symbol           (symbol),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_symbol       (out_symbol),
        .occurrences      (occurrences),
        .share_hundredths (share_hundredths),
        .exhausted        (exhausted)
    );

    // 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // report for one symbol, or the nothing-left beat with all fields zero
    function automatic report_t form_report(bit found, int unsigned idx);
        report_t          r;
        longint unsigned  q;
        r.sym   = '0;
        r.occ   = '0;
        r.share = '0;
        r.none  = !found;
        if (found)
        begin
            r.sym = sym_t'(idx);
            r.occ = occ_t'(hist[idx]);
            // share in hundredths of a percent, truncated, never above full
            if (grand_total != 0)
            begin
                q = hist[idx];
                q = (q * SHARE_SCALE) / grand_total;
                if (q > SHARE_SCALE)
                    q = SHARE_SCALE;
                r.share = share_t'(q);
            end
        end
        return r;
    endfunction

    // apply one accepted beat to the histogram and queue any report it owes
    function automatic void histogram_apply(op_t code, sym_t sym);
        bit          found;
        int unsigned best;
        found = 1'b0;
        best  = 0;
        case (code)
            OP_CLEAR:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    hist[i]   = '0;
                    picked[i] = 1'b0;
                end
                grand_total = '0;
                seq_cursor  = 0;
            end
            OP_ADD:
            begin
                // symbols past the histogram are dropped, total untouched
                if (sym < SYMBOLS)
                begin
                    if (hist[sym] != CNT_MAX)
                        hist[sym]++;
                    if (grand_total != CNT_MAX)
                        grand_total++;
                end
            end
            OP_NEXT_ORDER:
            begin
                for (int i = seq_cursor; i < SYMBOLS && !found; i++)
                    if (hist[i] != 0)
                    begin
                        found = 1'b1;
                        best  = i;
                    end
                seq_cursor = found ? best + 1 : SYMBOLS;
                reports_due.push_back(form_report(found, best));
            end
            OP_NEXT_FREQ:
            begin
                // strict greater keeps ties on the lowest symbol
                for (int i = 0; i < SYMBOLS; i++)
                    if (!picked[i] && hist[i] != 0 && (!found || hist[i] > hist[best]))
                    begin
                        found = 1'b1;
                        best  = i;
                    end
                if (found)
                    picked[best] = 1'b1;
                reports_due.push_back(form_report(found, best));
            end
            OP_REWIND:
            begin
                seq_cursor = 0;
                for (int i = 0; i < SYMBOLS; i++)
                    picked[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // offer one input beat and hold it until taken
    task automatic offer_beat(op_t code, sym_t sym);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        // valid stays high straight into the next beat when there is no gap
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        symbol   <= sym;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        histogram_apply(code, sym);
        beats_sent++;
    endtask

    // mostly a few hot symbols so that counts pile up and tie, some out of range
    function automatic sym_t random_symbol();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return sym_t'($urandom_range(0, 5));
        else if (pick < 9)
            return sym_t'($urandom_range(0, SYMBOLS - 1));
        else
            return sym_t'($urandom_range(SYMBOLS, 127));
    endfunction

    function automatic op_t random_spare_op();
        case ($urandom_range(0, 2))
            0:       return OP_SPARE5;
            1:       return OP_SPARE6;
            default: return OP_SPARE7;
        endcase
    endfunction

    // empty histogram straight after reset, plus beats that must change nothing
    task automatic test_empty_and_noise();
        offer_beat(OP_NEXT_ORDER, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(127));
        offer_beat(OP_SPARE5, sym_t'(3));
        offer_beat(OP_SPARE6, sym_t'(127));
        offer_beat(OP_SPARE7, sym_t'(0));
        // out of range adds are dropped
        offer_beat(OP_ADD, sym_t'(SYMBOLS));
        offer_beat(OP_ADD, sym_t'(127));
        offer_beat(OP_NEXT_ORDER, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
    endtask

    // both orders, ties, adds after reports, rewind and clear
    task automatic test_ranked_orders();
        offer_beat(OP_CLEAR, sym_t'(127));
        offer_beat(OP_ADD, sym_t'(0));
        offer_beat(OP_ADD, sym_t'(SYMBOLS - 1));
        offer_beat(OP_ADD, sym_t'(SYMBOLS - 1));
        offer_beat(OP_ADD, sym_t'(50));
        offer_beat(OP_ADD, sym_t'(50));
        offer_beat(OP_ADD, sym_t'(7));
        offer_beat(OP_ADD, sym_t'(7));
        // three-way tie, lowest symbol first
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        // a taken symbol stays taken though its count grows
        offer_beat(OP_ADD, sym_t'(7));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        offer_beat(OP_NEXT_ORDER, sym_t'(0));
        // cursor does not move back for a symbol below it
        offer_beat(OP_ADD, sym_t'(0));
        repeat (4) offer_beat(OP_NEXT_ORDER, sym_t'(0));
        offer_beat(OP_REWIND, sym_t'(0));
        offer_beat(OP_NEXT_ORDER, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        offer_beat(OP_CLEAR, sym_t'(0));
        offer_beat(OP_NEXT_ORDER, sym_t'(0));
    endtask

    // result side held off for long while reports keep coming, input must stall
    task automatic test_output_backpressure();
        tx_eager = 1'b1;
        offer_beat(OP_CLEAR, sym_t'(0));
        for (int k = 0; k < 6; k++)
            repeat (k + 1) offer_beat(OP_ADD, sym_t'(10 + k));
        rx_hold_cycles = 1500;
        repeat (4)
        begin
            offer_beat(OP_NEXT_FREQ, sym_t'(0));
            offer_beat(OP_NEXT_ORDER, sym_t'(0));
        end
        offer_beat(OP_ADD, sym_t'(11));
        offer_beat(OP_REWIND, sym_t'(0));
        offer_beat(OP_NEXT_FREQ, sym_t'(0));
        tx_eager = 1'b0;
    endtask

    // sessions of adds then a run of reports, with rewinds, clears and noise
    task automatic test_random_sessions();
        int unsigned stop_at;
        int          n;
        int          pick;
        stop_at = beats_sent + 600;
        while (beats_sent < stop_at)
        begin
            // now and then a stretch with no idling on one side or both
            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                offer_beat(OP_CLEAR, sym_t'($urandom_range(0, 127)));
            n = $urandom_range(0, 24);
            repeat (n) offer_beat(OP_ADD, random_symbol());
            n = $urandom_range(1, 14);
            repeat (n)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    offer_beat(OP_NEXT_ORDER, sym_t'($urandom_range(0, 127)));
                else if (pick < 17)
                    offer_beat(OP_NEXT_FREQ, sym_t'($urandom_range(0, 127)));
                else if (pick < 19)
                    offer_beat(OP_REWIND, sym_t'($urandom_range(0, 127)));
                else
                    offer_beat(random_spare_op(), sym_t'($urandom_range(0, 127)));
            end
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // result side stall, drawn per beat, with the long hold-off on request
    initial
    begin : result_stall_driver
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                n = rx_eager ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            // wait for the next beat taken, or a hold-off asked for meanwhile
            forever
            begin
                @(posedge clk);
                if (out_valid === 1'b1 && out_stall === 1'b0)
                    break;
                if (rx_hold_cycles > 0)
                    break;
            end
        end
    end

    // every result beat against the oldest report owed
    always @(posedge clk)
    begin : result_check
        report_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t unexpected result beat: symbol %0d occurrences %0d",
                         $time, out_symbol, occurrences);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (out_symbol !== want.sym)
                begin
                    $display("%0t out_symbol expected %0d actual %0d",
                             $time, want.sym, out_symbol);
                    mismatches++;
                end
                if (occurrences !== want.occ)
                begin
                    $display("%0t occurrences expected %0d actual %0d",
                             $time, want.occ, occurrences);
                    mismatches++;
                end
                if (share_hundredths !== want.share)
                begin
                    $display("%0t share_hundredths expected %0d actual %0d",
                             $time, want.share, share_hundredths);
                    mismatches++;
                end
                if (exhausted !== want.none)
                begin
                    $display("%0t exhausted expected %0b actual %0b",
                             $time, want.none, exhausted);
                    mismatches++;
                end
            end
        end
    end

    // hard limit, well past the slowest correct run
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        op       <= OP_CLEAR;
        symbol   <= '0;
        // model starts from the reset state
        histogram_apply(OP_CLEAR, '0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_noise();
        test_ranked_orders();
        test_output_backpressure();
        test_random_sessions();

        // let every owed report drain, then allow for a stray late beat
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
